>>> src/palette_nearest_color_map_core_macros.svh
// Assertion macros shared by the palette color mapper.
`ifndef PALETTE_NEAREST_COLOR_MAP_CORE_MACROS_SVH
`define PALETTE_NEAREST_COLOR_MAP_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PNCM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PNCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pncm_pkg.sv
// Package with types, codes and defaults of the palette color mapper.
`timescale 1ns / 1ps

package pncm_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int CH_W    = 8;
    localparam int DIST_W  = 10;
    localparam int PIXEL_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int S_TDATA_W  = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_MODE    = 3'd0,
        CFG_PALETTE_COUNT = 3'd1,
        CFG_RED_BYTE      = 3'd2,
        CFG_GREEN_BYTE    = 3'd3,
        CFG_BLUE_BYTE     = 3'd4,
        CFG_ALPHA_BYTE    = 3'd5,
        CFG_ALPHA_ENABLE  = 3'd6
    } cfg_idx_t;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_MAP   = 1'b1;

    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_PACKED  = 1'b1;

    localparam logic [0:0]            RST_PIXEL_MODE    = 1'b0;
    localparam logic [CFG_DATA_W-1:0] RST_PALETTE_COUNT = 9'd256;
    localparam logic [1:0]            RST_RED_BYTE      = 2'd2;
    localparam logic [1:0]            RST_GREEN_BYTE    = 2'd1;
    localparam logic [1:0]            RST_BLUE_BYTE     = 2'd0;
    localparam logic [1:0]            RST_ALPHA_BYTE    = 2'd3;
    localparam logic [0:0]            RST_ALPHA_ENABLE  = 1'b0;

    typedef struct packed {
        logic clear_wr;
        logic pal_wr;
        logic load;
        logic search_step;
        logic result_load;
    } pncm_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic issue_last;
        logic limit_zero;
        logic out_free;
    } pncm_status_t;

endpackage

>>> src/palette_nearest_color_map_core.sv
// Maps an RGBA color to a pixel value, either the index of the nearest palette entry by
// Manhattan distance over red, green and blue (ties to the lowest index), or the channels
// packed at configured byte positions. A palette write (tuser 0) gives no result. A
// palette-mode map searches min(palette_count, PALETTE_ENTRIES) entries through the
// single read port of the palette memory, which yields one entry per cycle to the
// distance compare; a count of zero gives 0. A map whose result finds the previous one
// still pending on m_tdata also waits for that transaction. After reset a clearing pass
// zeroes the palette with s_tready low; configuration writes are taken throughout.
`timescale 1ns / 1ps

`include "palette_nearest_color_map_core_macros.svh"

module palette_nearest_color_map_core
    import pncm_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // entry_index[7:0], red[15:8], green[23:16], blue[31:24], alpha[39:32]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_value[31:0]
    output logic [PIXEL_W-1:0]    m_tdata
);

    logic                  pixel_mode_reg;
    logic [CFG_DATA_W-1:0] palette_count_reg;
    logic [1:0]            red_byte_reg;
    logic [1:0]            green_byte_reg;
    logic [1:0]            blue_byte_reg;
    logic [1:0]            alpha_byte_reg;
    logic                  alpha_enable_reg;

    pncm_cmd_t    cmd;
    pncm_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_mode_reg    <= RST_PIXEL_MODE;
            palette_count_reg <= RST_PALETTE_COUNT;
            red_byte_reg      <= RST_RED_BYTE;
            green_byte_reg    <= RST_GREEN_BYTE;
            blue_byte_reg     <= RST_BLUE_BYTE;
            alpha_byte_reg    <= RST_ALPHA_BYTE;
            alpha_enable_reg  <= RST_ALPHA_ENABLE;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PIXEL_MODE:    pixel_mode_reg    <= cfg_wdata[0];
                CFG_PALETTE_COUNT: palette_count_reg <= cfg_wdata;
                CFG_RED_BYTE:      red_byte_reg      <= cfg_wdata[1:0];
                CFG_GREEN_BYTE:    green_byte_reg    <= cfg_wdata[1:0];
                CFG_BLUE_BYTE:     blue_byte_reg     <= cfg_wdata[1:0];
                CFG_ALPHA_BYTE:    alpha_byte_reg    <= cfg_wdata[1:0];
                CFG_ALPHA_ENABLE:  alpha_enable_reg  <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    pncm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .req_type   (s_tuser),
        .pixel_mode (pixel_mode_reg),
        .status     (status),
        .cmd        (cmd)
    );

    pncm_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_tdata       (s_tdata),
        .pixel_mode    (pixel_mode_reg),
        .palette_count (palette_count_reg),
        .red_byte      (red_byte_reg),
        .green_byte    (green_byte_reg),
        .blue_byte     (blue_byte_reg),
        .alpha_byte    (alpha_byte_reg),
        .alpha_enable  (alpha_enable_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    `PNCM_ASSERT_NOW(a_load_into_free_output, aclk, aresetn, cmd.result_load, (!m_tvalid || m_tready), "result loaded over a pending transaction")
    `PNCM_ASSERT_NOW(a_no_accept_while_clearing, aclk, aresetn, cmd.clear_wr, !s_tready, "input accepted during palette clear")
    `PNCM_ASSERT_NEXT(a_write_returns_ready, aclk, aresetn, (s_tvalid && s_tready && (s_tuser == REQ_WRITE)), s_tready, "palette write did not return to ready")

endmodule

>>> src/pncm_ctrl.sv
// Controller state machine of the palette color mapper.
`timescale 1ns / 1ps

module pncm_ctrl
    import pncm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic         req_type,
    input  logic         pixel_mode,
    input  pncm_status_t status,
    output pncm_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd.clear_wr    = (state_reg == ST_CLEAR);
        cmd.load        = accept;
        cmd.pal_wr      = accept && (req_type == REQ_WRITE);
        cmd.search_step = (state_reg == ST_SEARCH);
        cmd.result_load = (state_reg == ST_DONE) && status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept && (req_type == REQ_MAP)) begin
                    if (pixel_mode == MODE_PACKED || status.limit_zero) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (status.issue_last) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/pncm_datapath.sv
// Datapath of the palette color mapper: palette memory, search and result register.
`timescale 1ns / 1ps

module pncm_datapath
    import pncm_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pncm_cmd_t             cmd,
    output pncm_status_t          status,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  pixel_mode,
    input  logic [CFG_DATA_W-1:0] palette_count,
    input  logic [1:0]            red_byte,
    input  logic [1:0]            green_byte,
    input  logic [1:0]            blue_byte,
    input  logic [1:0]            alpha_byte,
    input  logic                  alpha_enable,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_W-1:0]    m_tdata
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

    logic [3*CH_W-1:0] mem [PALETTE_ENTRIES];

    logic [CH_W-1:0]     in_index;
    logic [CH_W-1:0]     in_red;
    logic [CH_W-1:0]     in_green;
    logic [CH_W-1:0]     in_blue;
    logic [31:0]         in_index_ext;
    logic                in_range;

    logic [CH_W-1:0]     red_reg;
    logic [CH_W-1:0]     green_reg;
    logic [CH_W-1:0]     blue_reg;
    logic [CH_W-1:0]     alpha_reg;

    logic [IDX_W-1:0]    clr_addr_reg;
    logic [IDX_W-1:0]    rd_addr_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                cmp_valid_reg;
    logic [3*CH_W-1:0]   rdata_reg;
    logic [DIST_W-1:0]   best_dist_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic                m_tvalid_reg;
    logic [PIXEL_W-1:0]  m_tdata_reg;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [3*CH_W-1:0]   mem_wdata;
    logic [CNT_W-1:0]    limit;
    logic [DIST_W-1:0]   cand_dist;
    logic [PIXEL_W-1:0]  packed_pixel;
    logic [PIXEL_W-1:0]  result;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] x,
                                                 input logic [CH_W-1:0] y);
        return (x > y) ? (x - y) : (y - x);
    endfunction

    assign in_index     = s_tdata[7:0];
    assign in_red       = s_tdata[15:8];
    assign in_green     = s_tdata[23:16];
    assign in_blue      = s_tdata[31:24];
    assign in_index_ext = 32'(in_index);
    assign in_range     = in_index_ext < 32'(PALETTE_ENTRIES);

    assign limit = (32'(palette_count) > 32'(PALETTE_ENTRIES)) ? CNT_W'(PALETTE_ENTRIES)
                                                               : CNT_W'(palette_count);

    always_comb begin
        mem_we    = cmd.clear_wr || (cmd.pal_wr && in_range);
        mem_waddr = cmd.clear_wr ? clr_addr_reg : in_index_ext[IDX_W-1:0];
        mem_wdata = cmd.clear_wr ? '0 : {in_red, in_green, in_blue};
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (cmd.search_step) rdata_reg <= mem[rd_addr_reg];
    end

    assign cand_dist = DIST_W'(abs_diff(rdata_reg[23:16], red_reg))
                     + DIST_W'(abs_diff(rdata_reg[15:8], green_reg))
                     + DIST_W'(abs_diff(rdata_reg[7:0], blue_reg));

    assign packed_pixel = (PIXEL_W'(red_reg) << {red_byte, 3'b000})
                        | (PIXEL_W'(green_reg) << {green_byte, 3'b000})
                        | (PIXEL_W'(blue_reg) << {blue_byte, 3'b000})
                        | (alpha_enable ? (PIXEL_W'(alpha_reg) << {alpha_byte, 3'b000})
                                        : '0);

    assign result = (pixel_mode == MODE_PACKED) ? packed_pixel : PIXEL_W'(best_idx_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            red_reg   <= in_red;
            green_reg <= in_green;
            blue_reg  <= in_blue;
            alpha_reg <= s_tdata[39:32];
        end
        cmp_idx_reg <= rd_addr_reg;
        if (cmd.result_load) m_tdata_reg <= result;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg  <= '0;
            rd_addr_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd.clear_wr) clr_addr_reg <= clr_addr_reg + 1'b1;
            cmp_valid_reg <= cmd.search_step;
            if (cmd.load) begin
                rd_addr_reg   <= '0;
                best_dist_reg <= '1;
                best_idx_reg  <= '0;
            end else begin
                if (cmd.search_step) rd_addr_reg <= rd_addr_reg + 1'b1;
                // keep the first entry on ties
                if (cmp_valid_reg && (cand_dist < best_dist_reg)) begin
                    best_dist_reg <= cand_dist;
                    best_idx_reg  <= cmp_idx_reg;
                end
            end
            if (cmd.result_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        status.clear_last = (clr_addr_reg == IDX_W'(PALETTE_ENTRIES - 1));
        status.issue_last = (CNT_W'(rd_addr_reg) == (limit - 1'b1));
        status.limit_zero = (limit == '0);
        status.out_free   = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
